@@ rtl/rirr_pkg.sv @@
// ----------------------------------------------------------------------------
// rirr_pkg: shared types and constants of the ratio image range rescale unit
// Payload structs, lane control, register indexes and controller states.
// ----------------------------------------------------------------------------
package rirr_pkg;

	localparam int RATIO_FRAC_BITS_DEF = 8;
	localparam int NUM_LANES           = 3;
	localparam int RATIO_W             = 16;
	localparam int TARGET_W            = 8;
	localparam int VALUE_W             = 8;
	localparam int SCALE_W             = 24;
	localparam int SCALE_FRAC          = 16;
	localparam int REG_IDX_W           = 3;

	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_SCALE   = 1'b1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RED_TARGET_LOW    = 3'd0,
		REG_RED_TARGET_HIGH   = 3'd1,
		REG_GREEN_TARGET_LOW  = 3'd2,
		REG_GREEN_TARGET_HIGH = 3'd3,
		REG_BLUE_TARGET_LOW   = 3'd4,
		REG_BLUE_TARGET_HIGH  = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic               opcode;
		logic               first_of_pass;
		logic [RATIO_W-1:0] red_ratio;
		logic [RATIO_W-1:0] green_ratio;
		logic [RATIO_W-1:0] blue_ratio;
	} pixel_t;

	typedef struct packed {
		logic [VALUE_W-1:0] red_value;
		logic [VALUE_W-1:0] green_value;
		logic [VALUE_W-1:0] blue_value;
		logic               clipped;
	} result_t;

	typedef struct packed {
		logic track_en;
		logic track_start;
		logic capture;
		logic div_load;
		logic div_step;
		logic scale_write;
		logic mul_en;
	} lane_ctrl_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               clip;
	} lane_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SCALE,
		ST_MULTIPLY,
		ST_DELIVER
	} state_t;

endpackage

@@ rtl/rirr_lane.sv @@
// ----------------------------------------------------------------------------
// rirr_lane: one colour channel of the rescale unit
// Tracks the channel extremes, divides the target spread by the measured
// spread one quotient bit per cycle, and multiplies and rounds each ratio.
// ----------------------------------------------------------------------------
module rirr_lane #(
	parameter int RATIO_FRAC_BITS = rirr_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rirr_pkg::lane_ctrl_t           ctrl,
	input  logic [rirr_pkg::RATIO_W-1:0]   ratio,
	input  logic [rirr_pkg::TARGET_W-1:0]  target_low,
	input  logic [rirr_pkg::TARGET_W-1:0]  target_high,
	output rirr_pkg::lane_res_t            res
);

	localparam int SHIFT   = RATIO_FRAC_BITS + rirr_pkg::SCALE_FRAC;
	localparam int NUM_W   = rirr_pkg::TARGET_W + SHIFT;
	localparam int PROD_W  = rirr_pkg::SCALE_W + rirr_pkg::RATIO_W;
	localparam int SUM_W   = PROD_W + 1;

	logic [rirr_pkg::RATIO_W-1:0]  seen_low_q, seen_high_q;
	logic [rirr_pkg::RATIO_W-1:0]  ratio_q;
	logic [rirr_pkg::RATIO_W-1:0]  divisor_q;
	logic [rirr_pkg::RATIO_W-1:0]  rem_q;
	logic [NUM_W-1:0]              quot_q;
	logic [rirr_pkg::SCALE_W-1:0]  scale_q;
	logic [PROD_W-1:0]             product_q;

	logic [rirr_pkg::TARGET_W-1:0] target_spread;
	logic [rirr_pkg::RATIO_W-1:0]  seen_spread;
	logic [rirr_pkg::RATIO_W:0]    trial;
	logic                          trial_ge;
	logic [rirr_pkg::RATIO_W:0]    trial_diff;
	logic [SUM_W-1:0]              rounded;
	logic [SUM_W-1:0]              shifted;

	assign target_spread = (target_high >= target_low) ? target_high - target_low
		: '0;
	assign seen_spread   = (seen_high_q > seen_low_q) ? seen_high_q - seen_low_q : '0;

	// Restoring division: the numerator shifts out of the top of quot_q while
	// quotient bits shift in at the bottom.
	assign trial      = {rem_q, quot_q[NUM_W-1]};
	assign trial_ge   = trial >= {1'b0, divisor_q};
	assign trial_diff = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_low_q  <= '0;
			seen_high_q <= '0;
			scale_q     <= '0;
		end else begin
			if (ctrl.track_en) begin
				if (ctrl.track_start) begin
					seen_low_q  <= ratio;
					seen_high_q <= ratio;
				end else begin
					if (ratio < seen_low_q)
						seen_low_q <= ratio;
					if (ratio > seen_high_q)
						seen_high_q <= ratio;
				end
			end
			if (ctrl.scale_write) begin
				if (divisor_q == '0)
					scale_q <= '0;
				else if (|quot_q[NUM_W-1:rirr_pkg::SCALE_W])
					scale_q <= '1;
				else
					scale_q <= quot_q[rirr_pkg::SCALE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture)
			ratio_q <= ratio;
		if (ctrl.div_load) begin
			divisor_q <= seen_spread;
			rem_q     <= '0;
			quot_q    <= {target_spread, {SHIFT{1'b0}}};
		end else if (ctrl.div_step) begin
			rem_q  <= trial_ge ? trial_diff[rirr_pkg::RATIO_W-1:0]
				: trial[rirr_pkg::RATIO_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], trial_ge};
		end
		if (ctrl.mul_en)
			product_q <= scale_q * ratio_q;
	end

	// Round half up, then saturate at the largest output value.
	assign rounded = {1'b0, product_q} + (SUM_W'(1) << (SHIFT - 1));
	assign shifted = rounded >> SHIFT;

	always_comb begin
		res.clip  = |shifted[SUM_W-1:rirr_pkg::VALUE_W];
		res.value = res.clip ? '1 : shifted[rirr_pkg::VALUE_W-1:0];
	end

endmodule

@@ rtl/rirr_merge.sv @@
// ----------------------------------------------------------------------------
// rirr_merge: result register of the rescale unit
// Gathers the three lane values, combines their clip flags and holds the
// result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module rirr_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  rirr_pkg::lane_res_t lane_res [rirr_pkg::NUM_LANES],
	output logic                free,
	output logic                result_valid,
	input  logic                result_stall,
	output rirr_pkg::result_t   result
);

	logic              valid_q;
	rirr_pkg::result_t result_q;

	assign free         = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (!result_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.red_value   <= lane_res[0].value;
			result_q.green_value <= lane_res[1].value;
			result_q.blue_value  <= lane_res[2].value;
			result_q.clipped     <= lane_res[0].clip | lane_res[1].clip | lane_res[2].clip;
		end
	end

endmodule

@@ rtl/ratio_image_range_rescale_unit.sv @@
// ----------------------------------------------------------------------------
// ratio_image_range_rescale_unit: two-pass min/max rescale of three ratios
// Top level: configuration registers, pass controller, three channel lanes
// and the result register.
// ----------------------------------------------------------------------------
// A measure-pass pixel is taken without leaving the idle state and gives no
// result. A scale-pass pixel goes from acceptance to the result register
// through capture, multiply, and round and saturate, and the unit takes no new
// pixel until that result is loaded into the result register. The first pixel of a
// scale pass first runs the three lane dividers in parallel, one quotient bit
// per cycle, before its scale is written (ratios in the default Q8.8
// format). A finished result waits in the output register while the next
// pixel is accepted and worked on. The user must make configuration writes
// only while no pixel is in progress; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module ratio_image_range_rescale_unit #(
	parameter int RATIO_FRAC_BITS = rirr_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [rirr_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [rirr_pkg::TARGET_W-1:0]   wr_data,
	input  logic                            pixel_valid,
	output logic                            pixel_stall,
	input  rirr_pkg::pixel_t                pixel,
	output logic                            result_valid,
	input  logic                            result_stall,
	output rirr_pkg::result_t               result
);

	localparam int NUM_W = rirr_pkg::TARGET_W + RATIO_FRAC_BITS + rirr_pkg::SCALE_FRAC;
	localparam int CNT_W = $clog2(NUM_W);

	rirr_pkg::state_t     state_q, state_next;
	logic [CNT_W-1:0]     count_q;
	logic                 count_last;
	logic                 accept;
	logic                 merge_free;
	logic                 out_load;
	rirr_pkg::lane_ctrl_t lane_ctrl;

	logic [rirr_pkg::TARGET_W-1:0] target_low_q  [rirr_pkg::NUM_LANES];
	logic [rirr_pkg::TARGET_W-1:0] target_high_q [rirr_pkg::NUM_LANES];
	logic [rirr_pkg::RATIO_W-1:0]  lane_ratio    [rirr_pkg::NUM_LANES];
	rirr_pkg::lane_res_t           lane_res      [rirr_pkg::NUM_LANES];

	assign pixel_stall = state_q != rirr_pkg::ST_IDLE;
	assign accept      = pixel_valid && !pixel_stall;
	assign count_last  = count_q == CNT_W'(NUM_W - 1);

	assign lane_ratio[0] = pixel.red_ratio;
	assign lane_ratio[1] = pixel.green_ratio;
	assign lane_ratio[2] = pixel.blue_ratio;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rirr_pkg::NUM_LANES; i++) begin
				target_low_q[i]  <= '0;
				target_high_q[i] <= '1;
			end
		end else if (wr_en) begin
			case (rirr_pkg::reg_index_t'(wr_index))
				rirr_pkg::REG_RED_TARGET_LOW:    target_low_q[0]  <= wr_data;
				rirr_pkg::REG_RED_TARGET_HIGH:   target_high_q[0] <= wr_data;
				rirr_pkg::REG_GREEN_TARGET_LOW:  target_low_q[1]  <= wr_data;
				rirr_pkg::REG_GREEN_TARGET_HIGH: target_high_q[1] <= wr_data;
				rirr_pkg::REG_BLUE_TARGET_LOW:   target_low_q[2]  <= wr_data;
				rirr_pkg::REG_BLUE_TARGET_HIGH:  target_high_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rirr_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == rirr_pkg::ST_DIVIDE)
				count_q <= count_q + CNT_W'(1);
			else
				count_q <= '0;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			rirr_pkg::ST_IDLE: begin
				if (accept && pixel.opcode == rirr_pkg::OP_SCALE)
					state_next = pixel.first_of_pass ? rirr_pkg::ST_DIVIDE
						: rirr_pkg::ST_MULTIPLY;
			end
			rirr_pkg::ST_DIVIDE: begin
				if (count_last)
					state_next = rirr_pkg::ST_SCALE;
			end
			rirr_pkg::ST_SCALE:    state_next = rirr_pkg::ST_MULTIPLY;
			rirr_pkg::ST_MULTIPLY: state_next = rirr_pkg::ST_DELIVER;
			rirr_pkg::ST_DELIVER: begin
				if (merge_free)
					state_next = rirr_pkg::ST_IDLE;
			end
			default: state_next = rirr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		lane_ctrl = '0;
		out_load  = 1'b0;
		case (state_q)
			rirr_pkg::ST_IDLE: begin
				lane_ctrl.track_en    = accept && pixel.opcode == rirr_pkg::OP_MEASURE;
				lane_ctrl.track_start = pixel.first_of_pass;
				lane_ctrl.capture     = accept && pixel.opcode == rirr_pkg::OP_SCALE;
				lane_ctrl.div_load    = accept && pixel.opcode == rirr_pkg::OP_SCALE
					&& pixel.first_of_pass;
			end
			rirr_pkg::ST_DIVIDE:   lane_ctrl.div_step    = 1'b1;
			rirr_pkg::ST_SCALE:    lane_ctrl.scale_write = 1'b1;
			rirr_pkg::ST_MULTIPLY: lane_ctrl.mul_en      = 1'b1;
			rirr_pkg::ST_DELIVER:  out_load              = merge_free;
			default: ;
		endcase
	end

	for (genvar g = 0; g < rirr_pkg::NUM_LANES; g++) begin : g_lane
		rirr_lane #(
			.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (lane_ctrl),
			.ratio      (lane_ratio[g]),
			.target_low (target_low_q[g]),
			.target_high(target_high_q[g]),
			.res        (lane_res[g])
		);
	end

	rirr_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (out_load),
		.lane_res    (lane_res),
		.free        (merge_free),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

@@ test/tb_ratio_image_range_rescale_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ratio_image_range_rescale_unit: self-checking bench of the range rescaler
// A directed table followed by randomised measure and scale frames. An
// in-bench predictor tracks the measured extremes and the channel scales and
// checks every result in order, under several target settings and idling
// patterns.
// ----------------------------------------------------------------------------
module tb_ratio_image_range_rescale_unit;

	localparam int FRAC          = rirr_pkg::RATIO_FRAC_BITS_DEF;
	localparam int SHIFT         = FRAC + rirr_pkg::SCALE_FRAC;
	localparam int SETTLE_CYCLES = 24 + FRAC + 1 + 8;
	localparam int NUM_LANES     = rirr_pkg::NUM_LANES;
	localparam int RATIO_W       = rirr_pkg::RATIO_W;
	localparam int TARGET_W      = rirr_pkg::TARGET_W;
	localparam int VALUE_W       = rirr_pkg::VALUE_W;
	localparam int SCALE_W       = rirr_pkg::SCALE_W;

	// Short names for the opcodes keep the stimulus table readable.
	localparam logic OP_MEASURE = rirr_pkg::OP_MEASURE;
	localparam logic OP_SCALE   = rirr_pkg::OP_SCALE;

	typedef enum {ROW_PIXEL, ROW_TARGETS} row_kind_t;
	typedef enum {TGT_RESET, TGT_ZERO, TGT_TOP, TGT_INVERTED, TGT_RANDOM} target_mode_t;

	typedef struct {
		row_kind_t          kind;
		target_mode_t       tgt;
		logic               op;
		logic               first;
		logic [RATIO_W-1:0] r;
		logic [RATIO_W-1:0] g;
		logic [RATIO_W-1:0] b;
		bit                 literal;
		rirr_pkg::result_t  want;
	} stim_row_t;

	typedef struct {
		target_mode_t tgt;
		int           idle_pct;
		int           stall_pct;
		int           items;
		int           hold;
	} phase_t;

	localparam rirr_pkg::result_t ZERO_RES = '0;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    wr_en        = 1'b0;
	logic [rirr_pkg::REG_IDX_W-1:0] wr_index = '0;
	logic [TARGET_W-1:0]            wr_data  = '0;
	logic    pixel_valid  = 1'b0;
	logic    pixel_stall;
	rirr_pkg::pixel_t  pixel = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	rirr_pkg::result_t result;

	// Predictor state
	logic [TARGET_W-1:0] target_lo [NUM_LANES];
	logic [TARGET_W-1:0] target_hi [NUM_LANES];
	logic [RATIO_W-1:0]  seen_lo [NUM_LANES];
	logic [RATIO_W-1:0]  seen_hi [NUM_LANES];
	logic [SCALE_W-1:0]  chan_scale [NUM_LANES];

	rirr_pkg::result_t expected_results [$];
	int      fail_count     = 0;
	int      send_idle_pct  = 0;
	int      stall_pct      = 0;
	int      hold_request   = 0;
	int      hold_left      = 0;

	stim_row_t directed_rows [24] = '{
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b1, 16'hFFFF, 16'h8000, 16'h0001, 1'b1, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_MEASURE, 1'b1, 16'h0000, 16'h0100, 16'h1234, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_MEASURE, 1'b0, 16'hFFFF, 16'h0100, 16'h1235, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_MEASURE, 1'b0, 16'h8000, 16'h0100, 16'h1234, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b0, 16'h0080, 16'h0080, 16'h0001, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b0, 16'h5555, 16'hAAAA, 16'h00FF, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_MEASURE, 1'b1, 16'h0100, 16'h0200, 16'h0000, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_MEASURE, 1'b0, 16'h0300, 16'h0200, 16'hFFFF, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b1, 16'h0100, 16'h0080, 16'h7FFF, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b0, 16'h0300, 16'h0000, 16'hFFFF, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_MEASURE, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b0, 16'h0200, 16'h0200, 16'h0200, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b1, 16'h0200, 16'h0200, 16'h0200, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_MEASURE, 1'b1, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b1, 16'h1234, 16'h5678, 16'h9ABC, 1'b1, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ZERO_RES},
		'{ROW_TARGETS, TGT_INVERTED, OP_MEASURE, 1'b0, 16'h0, 16'h0, 16'h0, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_MEASURE, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_MEASURE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, ZERO_RES},
		'{ROW_PIXEL, TGT_RESET, OP_SCALE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ZERO_RES},
		'{ROW_TARGETS, TGT_RESET, OP_MEASURE, 1'b0, 16'h0, 16'h0, 16'h0, 1'b0, ZERO_RES}
	};

	phase_t phases [9] = '{
		'{TGT_RANDOM,   0,  0,  140, 300},
		'{TGT_INVERTED, 82, 0,  100, 0},
		'{TGT_RESET,    0,  82, 140, 0},
		'{TGT_ZERO,     25, 25, 100, 0},
		'{TGT_RANDOM,   25, 25, 130, 0},
		'{TGT_TOP,      0,  0,  100, 0},
		'{TGT_RANDOM,   82, 0,  130, 0},
		'{TGT_RANDOM,   0,  82, 130, 0},
		'{TGT_RESET,    25, 25, 130, 0}
	};

	ratio_image_range_rescale_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1000000;
		$display("tb: failure");
		$finish;
	end

	// Scale of one channel: target spread over measured spread in Q8.16.
	function automatic logic [SCALE_W-1:0] range_scale(input int ch);
		logic [63:0] tspan;
		logic [63:0] mspan;
		logic [63:0] q;
		tspan = (target_hi[ch] >= target_lo[ch]) ?
			64'(target_hi[ch]) - 64'(target_lo[ch]) : 64'd0;
		mspan = (seen_hi[ch] > seen_lo[ch]) ? 64'(seen_hi[ch]) - 64'(seen_lo[ch]) : 64'd0;
		if (mspan == 0)
			return '0;
		q = (tspan << SHIFT) / mspan;
		return (q > 64'hFFFFFF) ? '1 : q[SCALE_W-1:0];
	endfunction

	// Returns the saturated value with the clip flag on top.
	function automatic logic [VALUE_W:0] rescale_lane(input logic [SCALE_W-1:0] s,
			input logic [RATIO_W-1:0] ratio);
		logic [63:0] v;
		v = (64'(s) * 64'(ratio) + (64'd1 << (SHIFT - 1))) >> SHIFT;
		if (v > 255)
			return {1'b1, 8'hFF};
		return {1'b0, v[VALUE_W-1:0]};
	endfunction

	function automatic bit rescale_predict(input rirr_pkg::pixel_t p,
			output rirr_pkg::result_t res);
		logic [RATIO_W-1:0] ratio [NUM_LANES];
		logic [VALUE_W:0]   lane [NUM_LANES];
		ratio[0] = p.red_ratio;
		ratio[1] = p.green_ratio;
		ratio[2] = p.blue_ratio;
		res = '0;
		if (p.opcode == OP_MEASURE) begin
			for (int ch = 0; ch < NUM_LANES; ch++) begin
				if (p.first_of_pass) begin
					seen_lo[ch] = ratio[ch];
					seen_hi[ch] = ratio[ch];
				end else begin
					if (ratio[ch] < seen_lo[ch]) seen_lo[ch] = ratio[ch];
					if (ratio[ch] > seen_hi[ch]) seen_hi[ch] = ratio[ch];
				end
			end
			return 1'b0;
		end
		for (int ch = 0; ch < NUM_LANES; ch++) begin
			if (p.first_of_pass)
				chan_scale[ch] = range_scale(ch);
			lane[ch] = rescale_lane(chan_scale[ch], ratio[ch]);
		end
		res.red_value   = lane[0][VALUE_W-1:0];
		res.green_value = lane[1][VALUE_W-1:0];
		res.blue_value  = lane[2][VALUE_W-1:0];
		res.clipped     = lane[0][VALUE_W] | lane[1][VALUE_W] | lane[2][VALUE_W];
		return 1'b1;
	endfunction

	function automatic rirr_pkg::pixel_t make_pixel(input logic op, input logic first,
			input logic [RATIO_W-1:0] r, input logic [RATIO_W-1:0] g,
			input logic [RATIO_W-1:0] b);
		rirr_pkg::pixel_t p;
		p.opcode        = op;
		p.first_of_pass = first;
		p.red_ratio     = r;
		p.green_ratio   = g;
		p.blue_ratio    = b;
		return p;
	endfunction

	task automatic note_failure(input string what, input rirr_pkg::result_t want,
			input rirr_pkg::result_t got);
		if (fail_count < 10)
			$display("%s: expected %0d %0d %0d clip %0d, got %0d %0d %0d clip %0d", what,
				want.red_value, want.green_value, want.blue_value, want.clipped,
				got.red_value, got.green_value, got.blue_value, got.clipped);
		fail_count++;
	endtask

	always @(posedge clk) begin
		rirr_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				note_failure("unexpected result", ZERO_RES, result);
			end else begin
				want = expected_results.pop_front();
				if (result.red_value !== want.red_value ||
						result.green_value !== want.green_value ||
						result.blue_value !== want.blue_value ||
						result.clipped !== want.clipped)
					note_failure("result mismatch", want, result);
			end
		end
	end

	// Receiver side: random stalls, or a long hold-off counted here.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	// Returns at the edge where the request is taken; valid is left high so
	// that the next request can follow without a gap.
	task automatic offer_pixel(input rirr_pkg::pixel_t p);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel       <= p;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
	endtask

	task automatic send_pixel(input rirr_pkg::pixel_t p);
		rirr_pkg::result_t res;
		offer_pixel(p);
		if (rescale_predict(p, res))
			expected_results.push_back(res);
	endtask

	task automatic wait_drained();
		pixel_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	task automatic write_reg(input rirr_pkg::reg_index_t idx,
			input logic [TARGET_W-1:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
	endtask

	task automatic apply_targets(input target_mode_t mode);
		logic [TARGET_W-1:0] lo [NUM_LANES];
		logic [TARGET_W-1:0] hi [NUM_LANES];
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int ch = 0; ch < NUM_LANES; ch++) begin
			case (mode)
				TGT_RESET: begin
					lo[ch] = 8'd0;
					hi[ch] = 8'd255;
				end
				TGT_ZERO: begin
					lo[ch] = 8'd0;
					hi[ch] = 8'd0;
				end
				TGT_TOP: begin
					lo[ch] = 8'd255;
					hi[ch] = 8'd255;
				end
				TGT_INVERTED: begin
					lo[ch] = 8'd255;
					hi[ch] = 8'd0;
				end
				default: begin
					lo[ch] = 8'($urandom);
					hi[ch] = 8'($urandom);
				end
			endcase
			target_lo[ch] = lo[ch];
			target_hi[ch] = hi[ch];
		end
		write_reg(rirr_pkg::REG_RED_TARGET_LOW, lo[0]);
		write_reg(rirr_pkg::REG_RED_TARGET_HIGH, hi[0]);
		write_reg(rirr_pkg::REG_GREEN_TARGET_LOW, lo[1]);
		write_reg(rirr_pkg::REG_GREEN_TARGET_HIGH, hi[1]);
		write_reg(rirr_pkg::REG_BLUE_TARGET_LOW, lo[2]);
		write_reg(rirr_pkg::REG_BLUE_TARGET_HIGH, hi[2]);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [RATIO_W-1:0] rand_ratio(input int unsigned base,
			input int unsigned span);
		if ($urandom_range(15, 0) == 0)
			return RATIO_W'($urandom);
		return RATIO_W'(base + $urandom_range(span, 0));
	endfunction

	// Mostly a measure pass followed by a scale pass with random content;
	// the rest is unframed noise and passes without a start pixel.
	task automatic run_frames(input int n_items);
		int          count;
		int          kind;
		int          len;
		int unsigned span [NUM_LANES];
		int unsigned base [NUM_LANES];
		int unsigned limit;
		count = 0;
		while (count < n_items) begin
			for (int ch = 0; ch < NUM_LANES; ch++) begin
				case ($urandom_range(3, 0))
					0: span[ch] = $urandom_range(255, 0);
					1: span[ch] = $urandom_range(4095, 1);
					2: span[ch] = 65535;
					default: span[ch] = $urandom_range(65535, 0);
				endcase
				limit = 65535 - span[ch];
				if ($urandom_range(1, 0) && span[ch] < limit)
					limit = span[ch];
				base[ch] = $urandom_range(limit, 0);
			end
			kind = $urandom_range(9, 0);
			if (kind < 8) begin
				len = $urandom_range(8, 1);
				for (int i = 0; i < len; i++) begin
					send_pixel(make_pixel(OP_MEASURE, i == 0, rand_ratio(base[0], span[0]),
						rand_ratio(base[1], span[1]), rand_ratio(base[2], span[2])));
					count++;
				end
				len = $urandom_range(12, 1);
				for (int i = 0; i < len; i++) begin
					send_pixel(make_pixel(OP_SCALE, i == 0, rand_ratio(base[0], span[0]),
						rand_ratio(base[1], span[1]), rand_ratio(base[2], span[2])));
					count++;
				end
			end else if (kind == 8) begin
				len = $urandom_range(6, 1);
				for (int i = 0; i < len; i++) begin
					send_pixel(make_pixel(1'($urandom), 1'($urandom), RATIO_W'($urandom),
						RATIO_W'($urandom), RATIO_W'($urandom)));
					count++;
				end
			end else begin
				// Continue the previous passes: widen, then reuse stored scales.
				len = $urandom_range(4, 1);
				for (int i = 0; i < len; i++) begin
					send_pixel(make_pixel(i % 2 == 0 ? OP_MEASURE : OP_SCALE, 1'b0,
						rand_ratio(base[0], span[0]), rand_ratio(base[1], span[1]),
						rand_ratio(base[2], span[2])));
					count++;
				end
			end
			if ($urandom_range(29, 0) == 0)
				wait_drained();
		end
	endtask

	initial begin
		rirr_pkg::result_t res;
		for (int ch = 0; ch < NUM_LANES; ch++) begin
			target_lo[ch]  = 8'd0;
			target_hi[ch]  = 8'd255;
			seen_lo[ch]    = '0;
			seen_hi[ch]    = '0;
			chan_scale[ch] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_TARGETS) begin
				apply_targets(directed_rows[i].tgt);
			end else begin
				offer_pixel(make_pixel(directed_rows[i].op, directed_rows[i].first,
					directed_rows[i].r, directed_rows[i].g, directed_rows[i].b));
				if (rescale_predict(make_pixel(directed_rows[i].op, directed_rows[i].first,
						directed_rows[i].r, directed_rows[i].g, directed_rows[i].b), res))
					expected_results.push_back(directed_rows[i].literal ?
						directed_rows[i].want : res);
			end
		end

		foreach (phases[i]) begin
			apply_targets(phases[i].tgt);
			send_idle_pct = phases[i].idle_pct;
			stall_pct     = phases[i].stall_pct;
			hold_request  = phases[i].hold;
			run_frames(phases[i].items);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
